// ===== rtl/ffca_pkg.sv =====
// Shared widths, codes and state encoding for the first-fit cell allocator.
package ffca_pkg;

	localparam int ID_W    = 8;
	localparam int LEN_W   = 6;
	localparam int START_W = 5;
	localparam int FREED_W = 6;

	localparam logic [ID_W-1:0] FREE_ID = '0;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_INVALID = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE = 4'b0001,
		FSM_INJ  = 4'b0010,
		FSM_WAIT = 4'b0100,
		FSM_RESP = 4'b1000
	} fsm_t;

endpackage

// ===== rtl/first_fit_cell_allocator.sv =====
// Top level of the first-fit cell allocator: request control, cell chain and result register.
// A well-formed request is scanned and its result registered once the front leaves the chain;
// a rejected one skips the scan. A single scan front walks the cell chain one cell a cycle.
// Items are taken one at a time: the next is accepted only after the last result is loaded.
// Reset: every cell reads free straight after reset, no clearing pass; control idles.
module first_fit_cell_allocator #(
	parameter int CELLS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [ffca_pkg::ID_W-1:0]      proc_id,
	input  logic [ffca_pkg::LEN_W-1:0]     length,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [ffca_pkg::START_W-1:0]   start_cell,
	output logic [ffca_pkg::FREED_W-1:0]   cells_freed
);

	localparam int RW = $clog2(CELLS + 1);
	localparam int IW = $clog2(CELLS);
	localparam int CW = 3 + ffca_pkg::ID_W + RW + IW;
	localparam int WW = 2 + 2 * RW + 2 * IW;

	typedef struct packed {
		logic                      clr;
		logic                      alloc;
		logic                      commit;
		logic [ffca_pkg::ID_W-1:0] id;
		logic [RW-1:0]             len;
		logic [IW-1:0]             fstart;
	} ctl_t;

	typedef struct packed {
		logic          vld;
		logic          found;
		logic [RW-1:0] run;
		logic [IW-1:0] start;
		logic [IW-1:0] pos;
		logic [RW-1:0] cnt;
	} wave_t;

	ffca_pkg::fsm_t                state_q;
	logic                          alloc_q;
	logic [ffca_pkg::ID_W-1:0]     id_q;
	logic [RW-1:0]                 len_q;
	ffca_pkg::status_t             res_status_q;
	logic [IW-1:0]                 res_start_q;
	logic [RW-1:0]                 res_cnt_q;
	logic                          out_vld_q;
	ffca_pkg::status_t             out_status_q;
	logic [ffca_pkg::START_W-1:0]  out_start_q;
	logic [ffca_pkg::FREED_W-1:0]  out_cnt_q;

	logic                          accept;
	logic                          req_ok;
	logic [15:0]                   len_w;
	logic                          load_out;
	ctl_t                          ctl;
	wave_t                         inj;
	wave_t                         tail;
	logic [WW-1:0]                 chain [CELLS+1];
	logic [CELLS-1:0]              wave_vld;
	logic [31:0]                   start_ext;
	logic [31:0]                   cnt_ext;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ffca_pkg::FSM_IDLE);
	assign len_w    = 16'(length);
	assign req_ok   = (proc_id != ffca_pkg::FREE_ID) &&
		((op == ffca_pkg::OP_FREE) || ((len_w != 16'd0) && (len_w <= 16'(CELLS))));

	assign tail = wave_t'(chain[CELLS]);

	always_comb begin
		ctl.clr    = accept;
		ctl.alloc  = alloc_q;
		ctl.commit = (state_q == ffca_pkg::FSM_WAIT) && tail.vld && tail.found && alloc_q;
		ctl.id     = id_q;
		ctl.len    = len_q;
		ctl.fstart = tail.start;
		inj        = '0;
		inj.vld    = (state_q == ffca_pkg::FSM_INJ);
	end

	assign chain[0] = WW'(inj);

	genvar g;
	generate
		for (g = 0; g < CELLS; g++) begin : g_cell
			ffca_cell #(
				.RW (RW),
				.IW (IW)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (CW'(ctl)),
				.w_i    (chain[g]),
				.w_o    (chain[g+1])
			);
			assign wave_vld[g] = chain[g+1][WW-1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffca_pkg::FSM_IDLE;
		end else begin
			unique case (state_q)
				ffca_pkg::FSM_IDLE: begin
					if (accept) begin
						state_q <= req_ok ? ffca_pkg::FSM_INJ : ffca_pkg::FSM_RESP;
					end
				end
				ffca_pkg::FSM_INJ: begin
					state_q <= ffca_pkg::FSM_WAIT;
				end
				ffca_pkg::FSM_WAIT: begin
					if (tail.vld) begin
						state_q <= ffca_pkg::FSM_RESP;
					end
				end
				ffca_pkg::FSM_RESP: begin
					if (load_out) begin
						state_q <= ffca_pkg::FSM_IDLE;
					end
				end
				default: begin
					state_q <= ffca_pkg::FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			alloc_q      <= (op == ffca_pkg::OP_ALLOC);
			id_q         <= proc_id;
			len_q        <= RW'(length);
			res_status_q <= ffca_pkg::STAT_INVALID;
			res_start_q  <= '0;
			res_cnt_q    <= '0;
		end else if ((state_q == ffca_pkg::FSM_WAIT) && tail.vld) begin
			if (alloc_q) begin
				res_status_q <= tail.found ? ffca_pkg::STAT_DONE : ffca_pkg::STAT_NOSPACE;
				res_start_q  <= tail.found ? tail.start : '0;
				res_cnt_q    <= '0;
			end else begin
				res_status_q <= ffca_pkg::STAT_DONE;
				res_start_q  <= '0;
				res_cnt_q    <= tail.cnt;
			end
		end
	end

	assign load_out  = (state_q == ffca_pkg::FSM_RESP) && (!out_vld_q || !out_stall);
	assign start_ext = 32'(res_start_q);
	assign cnt_ext   = 32'(res_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_start_q  <= start_ext[ffca_pkg::START_W-1:0];
			out_cnt_q    <= cnt_ext[ffca_pkg::FREED_W-1:0];
		end
	end

	assign out_valid   = out_vld_q;
	assign status      = out_status_q;
	assign start_cell  = out_start_q;
	assign cells_freed = out_cnt_q;

`ifndef ASSERT_OFF
	a_tail_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (state_q == ffca_pkg::FSM_WAIT))
		else $error("scan front left the chain outside the wait state");

	a_single_front: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(wave_vld) <= 1)
		else $error("more than one scan front in the chain");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("next item taken before the current one finished");

	a_free_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (cells_freed != '0)) |-> (start_cell == '0))
		else $error("free result carries a start cell");
`endif

endmodule

// ===== rtl/ffca_cell.sv =====
// One storage cell of the allocator chain: owner id, run tracking and scan hand-off.
module ffca_cell #(
	parameter int RW = 6,
	parameter int IW = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [3+ffca_pkg::ID_W+RW+IW-1:0]   ctl,
	input  logic [2+2*RW+2*IW-1:0]              w_i,
	output logic [2+2*RW+2*IW-1:0]              w_o
);

	typedef struct packed {
		logic                      clr;
		logic                      alloc;
		logic                      commit;
		logic [ffca_pkg::ID_W-1:0] id;
		logic [RW-1:0]             len;
		logic [IW-1:0]             fstart;
	} ctl_t;

	typedef struct packed {
		logic          vld;
		logic          found;
		logic [RW-1:0] run;
		logic [IW-1:0] start;
		logic [IW-1:0] pos;
		logic [RW-1:0] cnt;
	} wave_t;

	ctl_t                      c;
	wave_t                     wi;
	wave_t                     wn;
	wave_t                     w_q;
	logic [ffca_pkg::ID_W-1:0] owner_q;
	logic                      tent_q;
	logic [IW-1:0]             tstart_q;
	logic                      is_free;
	logic                      take;
	logic                      release_me;
	logic [RW-1:0]             run_nx;

	assign c  = ctl_t'(ctl);
	assign wi = wave_t'(w_i);
	assign w_o = w_q;

	assign is_free    = (owner_q == ffca_pkg::FREE_ID);
	assign run_nx     = wi.run + RW'(1);
	assign take       = wi.vld && c.alloc && !wi.found && is_free;
	assign release_me = wi.vld && !c.alloc && (owner_q == c.id);

	always_comb begin
		wn     = wi;
		wn.pos = wi.pos + IW'(1);
		if (c.alloc) begin
			if (!wi.found) begin
				if (is_free) begin
					wn.run   = run_nx;
					wn.start = (wi.run == '0) ? wi.pos : wi.start;
					wn.found = (run_nx >= c.len);
				end else begin
					wn.run = '0;
				end
			end
		end else if (owner_q == c.id) begin
			wn.cnt = wi.cnt + RW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= '0;
			owner_q  <= ffca_pkg::FREE_ID;
			tent_q   <= 1'b0;
			tstart_q <= '0;
		end else begin
			w_q <= wn;
			priority if (c.clr) begin
				tent_q <= 1'b0;
			end else if (take) begin
				tent_q <= 1'b1;
			end else begin
				tent_q <= tent_q;
			end
			priority if (c.commit && tent_q && (tstart_q == c.fstart)) begin
				owner_q <= c.id;
			end else if (release_me) begin
				owner_q <= ffca_pkg::FREE_ID;
			end else begin
				owner_q <= owner_q;
			end
			if (take) begin
				tstart_q <= wn.start;
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the first-fit cell allocator: directed and random requests against a predictor.
module tb;

	localparam int CELLS = 32;

	typedef struct {
		ffca_pkg::status_t                   status;
		logic [ffca_pkg::START_W-1:0]        start_cell;
		logic [ffca_pkg::FREED_W-1:0]        cells_freed;
	} reply_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           op;
	logic [ffca_pkg::ID_W-1:0]      proc_id;
	logic [ffca_pkg::LEN_W-1:0]     length;
	logic                           out_valid;
	logic                           out_stall;
	logic [1:0]                     status;
	logic [ffca_pkg::START_W-1:0]   start_cell;
	logic [ffca_pkg::FREED_W-1:0]   cells_freed;

	logic [ffca_pkg::ID_W-1:0]      owner_map [CELLS];
	reply_t                         pending_replies [$];
	int                             mismatch_count;
	int                             send_idle_pct;
	int                             recv_stall_pct;

	first_fit_cell_allocator #(
		.CELLS(CELLS)
	) i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("Mismatches found");
		$finish;
	end

	function automatic void apply_request(ffca_pkg::op_t kind, logic [ffca_pkg::ID_W-1:0] id,
			logic [ffca_pkg::LEN_W-1:0] len);
		reply_t r;
		int     run;
		int     first;
		bit     found;
		r.status      = ffca_pkg::STAT_DONE;
		r.start_cell  = '0;
		r.cells_freed = '0;
		run   = 0;
		first = 0;
		found = 1'b0;
		if (id == ffca_pkg::FREE_ID) begin
			r.status = ffca_pkg::STAT_INVALID;
		end else if (kind == ffca_pkg::OP_ALLOC) begin
			if (len == 0 || len > CELLS) begin
				r.status = ffca_pkg::STAT_INVALID;
			end else begin
				for (int i = 0; i < CELLS && !found; i++) begin
					if (owner_map[i] == ffca_pkg::FREE_ID) begin
						run++;
						if (run >= len) begin
							first = i + 1 - run;
							found = 1'b1;
						end
					end else begin
						run = 0;
					end
				end
				if (!found) begin
					r.status = ffca_pkg::STAT_NOSPACE;
				end else begin
					for (int i = first; i < first + len; i++)
						owner_map[i] = id;
					r.start_cell = first[ffca_pkg::START_W-1:0];
				end
			end
		end else begin
			for (int i = 0; i < CELLS; i++) begin
				if (owner_map[i] == id) begin
					owner_map[i] = ffca_pkg::FREE_ID;
					r.cells_freed++;
				end
			end
		end
		pending_replies.push_back(r);
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				apply_request(ffca_pkg::op_t'(op), proc_id, length);
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					$error("result with no request waiting: status %0d", status);
					mismatch_count++;
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatch_count++;
					end
					if (start_cell !== want.start_cell) begin
						$error("start_cell: expected %0d, actual %0d",
							want.start_cell, start_cell);
						mismatch_count++;
					end
					if (cells_freed !== want.cells_freed) begin
						$error("cells_freed: expected %0d, actual %0d",
							want.cells_freed, cells_freed);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_item(ffca_pkg::op_t kind, logic [ffca_pkg::ID_W-1:0] id,
			logic [ffca_pkg::LEN_W-1:0] len);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		proc_id  <= id;
		length   <= len;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_for_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (CELLS + 8) @(negedge clk);
	endtask

	task automatic test_invalid_requests();
		send_item(ffca_pkg::OP_ALLOC, ffca_pkg::FREE_ID, 6'd4);
		send_item(ffca_pkg::OP_FREE, ffca_pkg::FREE_ID, 6'd0);
		send_item(ffca_pkg::OP_ALLOC, 8'd5, 6'd0);
		send_item(ffca_pkg::OP_ALLOC, 8'd5, 6'd33);
		send_item(ffca_pkg::OP_ALLOC, 8'd5, 6'd63);
		wait_for_replies();
	endtask

	task automatic test_whole_row();
		send_item(ffca_pkg::OP_ALLOC, 8'd255, 6'd32);
		send_item(ffca_pkg::OP_ALLOC, 8'd1, 6'd1);
		send_item(ffca_pkg::OP_FREE, 8'd255, 6'd63);
		wait_for_replies();
	endtask

	task automatic test_first_fit();
		send_item(ffca_pkg::OP_ALLOC, 8'd1, 6'd1);
		send_item(ffca_pkg::OP_ALLOC, 8'd2, 6'd3);
		send_item(ffca_pkg::OP_ALLOC, 8'd1, 6'd2);
		send_item(ffca_pkg::OP_FREE, 8'd2, 6'd0);
		send_item(ffca_pkg::OP_ALLOC, 8'd3, 6'd4);
		send_item(ffca_pkg::OP_ALLOC, 8'd4, 6'd3);
		send_item(ffca_pkg::OP_ALLOC, 8'd128, 6'd32);
		send_item(ffca_pkg::OP_FREE, 8'd77, 6'd0);
		send_item(ffca_pkg::OP_FREE, 8'd1, 6'd0);
		send_item(ffca_pkg::OP_FREE, 8'd3, 6'd0);
		send_item(ffca_pkg::OP_FREE, 8'd4, 6'd0);
		send_item(ffca_pkg::OP_ALLOC, 8'd170, 6'd31);
		send_item(ffca_pkg::OP_ALLOC, 8'd85, 6'd1);
		send_item(ffca_pkg::OP_FREE, 8'd170, 6'd0);
		send_item(ffca_pkg::OP_FREE, 8'd85, 6'd0);
		wait_for_replies();
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		int                          pick;
		ffca_pkg::op_t               kind;
		logic [ffca_pkg::ID_W-1:0]   id;
		logic [ffca_pkg::LEN_W-1:0]  len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 4)
				id = ffca_pkg::FREE_ID;
			else if (pick < 14)
				id = 8'($urandom_range(255, 1));
			else
				id = 8'($urandom_range(8, 1));
			kind = ($urandom_range(99) < 30) ? ffca_pkg::OP_FREE : ffca_pkg::OP_ALLOC;
			pick = $urandom_range(99);
			if (pick < 4)
				len = '0;
			else if (pick < 8)
				len = 6'($urandom_range(63, 33));
			else if (pick < 18)
				len = 6'($urandom_range(32, 9));
			else
				len = 6'($urandom_range(8, 1));
			send_item(kind, id, len);
		end
		wait_for_replies();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = ffca_pkg::OP_ALLOC;
		proc_id        = '0;
		length         = '0;
		mismatch_count = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < CELLS; i++)
			owner_map[i] = ffca_pkg::FREE_ID;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_invalid_requests();
		test_whole_row();
		test_first_fit();
		test_random(500, 0, 0);
		test_random(450, 66, 0);
		test_random(450, 0, 66);
		test_random(450, 16, 16);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
